// ----- src/assert_macros.svh -----
// Assertion helpers for the checker in lis_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LIS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LIS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/lis_pkg.sv -----
package lis_pkg;

  localparam int unsigned MAX_ITEMS = 1024;
  localparam int unsigned IDX_W     = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W     = $clog2(MAX_ITEMS + 1);
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned FIELD_W   = 11;
  localparam int unsigned OUT_W     = 4 * FIELD_W;
  localparam int unsigned TDATA_W   = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEARCH,
    ST_DONE
  } lis_state_e;

  typedef struct packed {
    logic load;    // latch the item, apply the start flag
    logic check;   // capacity check and search setup
    logic step;    // one lower-bound step on returned read data
    logic finish;  // tail write-back and result load
  } lis_cmd_t;

  typedef struct packed {
    logic full;       // capacity reached
    logic has_tails;  // at least one tail slot to search
    logic more;       // search interval still open after this step
    logic out_free;   // result register can take a new result
  } lis_stat_t;

endpackage

// ----- src/lis_ctrl.sv -----
module lis_ctrl
  import lis_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  lis_stat_t stat_i,
  output lis_cmd_t  cmd_o
);

  lis_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        if (!stat_i.full && stat_i.has_tails) begin
          state_d = ST_SEARCH;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SEARCH: begin
        cmd_o.step = 1'b1;
        if (!stat_i.more) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/lis_datapath.sv -----
module lis_datapath
  import lis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lis_cmd_t           cmd_i,
  output lis_stat_t          stat_o,
  input  logic [VAL_W-1:0]   value_i,
  input  logic               start_req_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [FIELD_W-1:0] position_o,
  output logic [FIELD_W-1:0] pred_index_o,
  output logic [FIELD_W-1:0] lis_length_o,
  output logic [FIELD_W-1:0] end_index_o,
  output logic               overflow_o
);

  localparam int unsigned MEM_W = VAL_W + CNT_W;

  // Tail store: value in the low bits, its position above.
  logic [MEM_W-1:0] mem_q [MAX_ITEMS];
  logic [MEM_W-1:0] rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  logic [VAL_W-1:0] key_q;
  logic [CNT_W-1:0] run_q, cnt_q, best_q, pos_q, pred_q;
  logic [CNT_W-1:0] lo_q, hi_q, mid_q;
  logic             ovf_q;

  logic             full;
  logic [CNT_W-1:0] mid_init;
  logic             less;
  logic [CNT_W-1:0] lo_n, hi_n, mid_n;
  logic [CNT_W-1:0] run_n, best_n;
  logic             grow;

  logic               out_valid_q;
  logic [FIELD_W-1:0] out_pos_q, out_pred_q, out_len_q, out_end_q;
  logic               out_ovf_q;

  assign full     = (cnt_q >= CNT_W'(MAX_ITEMS));
  assign mid_init = run_q >> 1;

  assign less  = ($signed(rdata_q[VAL_W-1:0]) < $signed(key_q));
  assign lo_n  = less ? (mid_q + CNT_W'(1)) : lo_q;
  assign hi_n  = less ? hi_q : mid_q;
  assign mid_n = lo_n + ((hi_n - lo_n) >> 1);

  assign grow   = !ovf_q && (lo_q == run_q);
  assign run_n  = grow ? (run_q + CNT_W'(1)) : run_q;
  assign best_n = grow ? pos_q : best_q;

  assign stat_o.full      = full;
  assign stat_o.has_tails = (run_q != '0);
  assign stat_o.more      = (lo_n < hi_n);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = mid_init[IDX_W-1:0];
    if (cmd_i.check) begin
      rd_en = !full && (run_q != '0);
    end else if (cmd_i.step) begin
      rd_en   = (lo_n < hi_n);
      rd_addr = mid_n[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
    if (cmd_i.finish && !ovf_q) begin
      mem_q[lo_q[IDX_W-1:0]] <= {pos_q, key_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      cnt_q  <= '0;
      best_q <= '0;
    end else begin
      if (cmd_i.load && start_req_i) begin
        run_q  <= '0;
        cnt_q  <= '0;
        best_q <= '0;
      end
      if (cmd_i.check && !full) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
      if (cmd_i.finish) begin
        run_q  <= run_n;
        best_q <= best_n;
      end
    end
  end

  // Search registers. The last slot that compared below the key is the one
  // just under the final lower bound, so its position is the predecessor.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= value_i;
    end
    if (cmd_i.check) begin
      ovf_q  <= full;
      pos_q  <= cnt_q + CNT_W'(1);
      lo_q   <= '0;
      hi_q   <= run_q;
      mid_q  <= mid_init;
      pred_q <= '0;
    end
    if (cmd_i.step) begin
      lo_q  <= lo_n;
      hi_q  <= hi_n;
      mid_q <= mid_n;
      if (less) begin
        pred_q <= rdata_q[MEM_W-1:VAL_W];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_pos_q  <= ovf_q ? '0 : FIELD_W'(pos_q);
      out_pred_q <= ovf_q ? '0 : FIELD_W'(pred_q);
      out_len_q  <= FIELD_W'(run_n);
      out_end_q  <= FIELD_W'(best_n);
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign position_o   = out_pos_q;
  assign pred_index_o = out_pred_q;
  assign lis_length_o = out_len_q;
  assign end_index_o  = out_end_q;
  assign overflow_o   = out_ovf_q;

endmodule

// ----- src/longest_increasing_subsequence_tracker.sv -----
// Longest strictly increasing subsequence tracker.
// Input channel s_axis: tdata carries the signed 32-bit value, tuser the start
// flag that clears the stored run before this item. Output channel m_axis:
// tdata carries position, pred_index, lis_length and end_index, 11 bits each;
// tuser is the overflow flag, set when the item came after the store was full
// and was ignored.
// An item goes from its accepting edge to a valid result through the capacity
// check and first tail read, then one binary-search step per returned read on
// the single registered read port of the tail memory, and then the tail write
// and result load. At most 1023 tails are searched. The next item is taken in
// the cycle after the result is loaded, so a new item is not accepted before
// the previous one is through.
// The result waits in an output register; while the receiver stalls a new item
// is still accepted and searched, and its result waits until the register
// frees. Reset empties the run and the output register; the tail memory needs
// no clearing because only slots written since the last start are read.
module longest_increasing_subsequence_tracker
  import lis_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [VAL_W-1:0]   s_axis_tdata_i,   // [31:0] value
  input  logic               s_axis_tuser_i,   // [0] start_req
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TDATA_W-1:0] m_axis_tdata_o,   // position, pred_index, lis_length,
                                               // end_index, then zero padding
  output logic               m_axis_tuser_o    // [0] overflow
);

  lis_cmd_t           cmd;
  lis_stat_t          stat;
  logic [FIELD_W-1:0] position, pred_index, lis_length, end_index;

  lis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lis_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .value_i      (s_axis_tdata_i),
    .start_req_i  (s_axis_tuser_i),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .position_o   (position),
    .pred_index_o (pred_index),
    .lis_length_o (lis_length),
    .end_index_o  (end_index),
    .overflow_o   (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = TDATA_W'({end_index, lis_length, pred_index, position});

endmodule

// ----- src/lis_checker.sv -----
`include "assert_macros.svh"

module lis_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [31:0] s_axis_tdata_i,
  input logic        s_axis_tuser_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [47:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o
);

  `LIS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o), "result changed while stalled")

  `LIS_ASSERT_NOW(a_ovf_zero, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tuser_o, m_axis_tdata_o[21:0] == 22'd0, "overflow result carries a position")

  `LIS_ASSERT_NOW(a_pred_order, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, (m_axis_tdata_o[10:0] != 11'd0) && (m_axis_tdata_o[21:11] < m_axis_tdata_o[10:0]), "predecessor not before the item")

  `LIS_ASSERT_NOW(a_len_valid, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, (m_axis_tdata_o[32:22] != 11'd0) && (m_axis_tdata_o[43:33] <= m_axis_tdata_o[10:0]), "longest run length or end out of range")

endmodule

bind longest_increasing_subsequence_tracker lis_checker u_lis_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tuser_i  (s_axis_tuser_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
